@@ sv/mnss_pkg.sv @@
`timescale 1ns / 1ps

package mnss_pkg;

	localparam int DEF_MAX_STATES  = 16;
	localparam int DEF_MAX_ACTIONS = 4;

	// 1.0 in unsigned Q1.16.
	localparam logic [16:0] Q_ONE = 17'h10000;

	localparam logic [4:0] NUM_STATES_RESET = 5'd16;

	// Stream widths: fields packed from bit 0 up, padded to whole bytes.
	localparam int IN_W  = 48;
	localparam int OUT_W = 8;

	// Configuration port.
	localparam int          PADDR_W      = 3;
	localparam logic        REG_NUM_STATES = 1'b0;

	// Command codes on the input stream.
	localparam logic [1:0] CMD_WRITE  = 2'd0;
	localparam logic [1:0] CMD_SAMPLE = 2'd1;
	localparam logic [1:0] CMD_XFORM  = 2'd2;

	localparam int QUEUE_DEPTH = 2;

	// Operation after classification by the front end.
	typedef enum logic [1:0] {
		OP_WRITE  = 2'd0,
		OP_SAMPLE = 2'd1,
		OP_XFORM  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  from_state;
		logic [1:0]  action;
		logic [3:0]  to_state;
		logic [16:0] value;
		logic [15:0] random_draw;
	} item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SAMPLE,
		ST_XF_RD,
		ST_XF_MUL,
		ST_XF_WR,
		ST_DONE
	} state_t;

endpackage

@@ sv/mnss_front.sv @@
`timescale 1ns / 1ps

module mnss_front import mnss_pkg::*; #(
	parameter int MAX_STATES  = DEF_MAX_STATES,
	parameter int MAX_ACTIONS = DEF_MAX_ACTIONS
) (
	input  logic            s_tvalid,
	output logic            s_tready,
	// command[1:0], from_state[5:2], action[7:6], to_state[11:8],
	// value[28:12], random_draw[44:29], zero[47:45]
	input  logic [IN_W-1:0] s_tdata,
	input  logic            q_full,
	output logic            q_push,
	output item_t           q_item
);

	logic [1:0]  command;
	logic [16:0] raw_value;
	logic        row_ok;
	logic        to_ok;

	assign s_tready = !q_full;
	assign q_push   = s_tvalid && !q_full;

	assign command   = s_tdata[1:0];
	assign raw_value = s_tdata[28:12];

	always_comb begin
		q_item.from_state  = s_tdata[5:2];
		q_item.action      = s_tdata[7:6];
		q_item.to_state    = s_tdata[11:8];
		q_item.random_draw = s_tdata[44:29];
		// Probabilities and tau above 1.0 are clipped to 1.0.
		q_item.value = (raw_value > Q_ONE) ? Q_ONE : raw_value;

		row_ok = (32'(q_item.from_state) < 32'(MAX_STATES)) &&
		         (32'(q_item.action) < 32'(MAX_ACTIONS));
		to_ok  = 32'(q_item.to_state) < 32'(MAX_STATES);

		case (command)
			CMD_WRITE:  q_item.op = (row_ok && to_ok) ? OP_WRITE : OP_NOP;
			CMD_SAMPLE: q_item.op = row_ok ? OP_SAMPLE : OP_NOP;
			CMD_XFORM:  q_item.op = OP_XFORM;
			default:    q_item.op = OP_NOP;
		endcase
	end

endmodule

@@ sv/mnss_queue.sv @@
`timescale 1ns / 1ps

module mnss_queue import mnss_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  valid,
	output item_t head_item
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	item_t         slots_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full      = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign valid     = (count_q != '0);
	assign head_item = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/mnss_back.sv @@
`timescale 1ns / 1ps

module mnss_back import mnss_pkg::*; #(
	parameter int MAX_STATES  = DEF_MAX_STATES,
	parameter int MAX_ACTIONS = DEF_MAX_ACTIONS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [4:0] num_states,
	input  logic       q_valid,
	input  item_t      q_item,
	output logic       q_pop,
	output logic       res_valid,
	input  logic       res_ready,
	output logic [3:0] res_next_state,
	output logic       res_found
);

	localparam int SW    = $clog2(MAX_STATES);
	localparam int NW    = $clog2(MAX_STATES + 1);
	localparam int AW    = (MAX_ACTIONS > 1) ? $clog2(MAX_ACTIONS) : 1;
	localparam int DEPTH = MAX_STATES * MAX_ACTIONS * MAX_STATES;
	localparam int ADW   = $clog2(DEPTH);
	localparam int SUMW  = 17 + SW;

	function automatic logic [ADW-1:0] cell_addr(input logic [ADW-1:0] s,
	                                             input logic [ADW-1:0] a,
	                                             input logic [ADW-1:0] j);
		logic [ADW-1:0] row;
		row = s * ADW'(MAX_ACTIONS) + a;
		return row * ADW'(MAX_STATES) + j;
	endfunction

	logic [16:0] mem [DEPTH];
	logic [16:0] rdata_q;

	state_t          state_q, state_d;
	logic            res_valid_q, res_valid_d;
	logic [3:0]      res_next_q, res_next_d;
	logic            res_found_q, res_found_d;
	logic [3:0]      fin_next_q, fin_next_d;
	logic            fin_found_q, fin_found_d;
	logic [NW-1:0]   iss_j_q, iss_j_d;
	logic            dv_s1, dv_d;
	logic [SW-1:0]   dj_s1, dj_d;
	logic [SUMW-1:0] sum_q, sum_d;
	logic [SW-1:0]   xs_q, xs_d;
	logic [AW-1:0]   xa_q, xa_d;
	logic [SW-1:0]   xj_q, xj_d;
	logic [33:0]     prod_s1, prod_d;

	logic            mem_we;
	logic [ADW-1:0]  mem_waddr;
	logic [16:0]     mem_wdata;
	logic [ADW-1:0]  mem_raddr;

	logic [NW-1:0]   n_act;
	logic            res_free;
	logic [SUMW-1:0] smp_sum;
	logic [SW-1:0]   smp_j;
	logic [16:0]     xf_diag;
	logic [18:0]     xf_raw;
	logic [16:0]     xf_val;
	logic [ADW-1:0]  xf_addr;
	logic            xf_j_wrap;
	logic            xf_a_wrap;
	logic            xf_s_wrap;

	// num_states above the table size acts as the table size.
	assign n_act = (32'(num_states) > 32'(MAX_STATES)) ? NW'(MAX_STATES) : NW'(num_states);

	assign res_free       = !res_valid_q || res_ready;
	assign res_valid      = res_valid_q;
	assign res_next_state = res_next_q;
	assign res_found      = res_found_q;

	assign smp_sum = sum_q + SUMW'(rdata_q);
	assign smp_j   = (iss_j_q < n_act) ? iss_j_q[SW-1:0] : '0;

	// tau*P + (1-tau) on the diagonal; the diagonal term is a whole multiple
	// of 2^16, so it can be added after the product is shifted down.
	assign xf_diag   = (xj_q == xs_q) ? (Q_ONE - q_item.value) : '0;
	assign xf_raw    = 19'(prod_s1[33:16]) + 19'(xf_diag);
	assign xf_val    = (xf_raw > 19'(Q_ONE)) ? Q_ONE : xf_raw[16:0];
	assign xf_addr   = cell_addr(ADW'(xs_q), ADW'(xa_q), ADW'(xj_q));
	assign xf_j_wrap = !((NW+1)'(xj_q) + 1'b1 < (NW+1)'(n_act));
	assign xf_a_wrap = !((AW+1)'(xa_q) + 1'b1 < (AW+1)'(MAX_ACTIONS));
	assign xf_s_wrap = !((NW+1)'(xs_q) + 1'b1 < (NW+1)'(n_act));

	always_comb begin
		state_d     = state_q;
		res_valid_d = res_valid_q && !res_ready;
		res_next_d  = res_next_q;
		res_found_d = res_found_q;
		fin_next_d  = fin_next_q;
		fin_found_d = fin_found_q;
		iss_j_d     = iss_j_q;
		dv_d        = 1'b0;
		dj_d        = dj_s1;
		sum_d       = sum_q;
		xs_d        = xs_q;
		xa_d        = xa_q;
		xj_d        = xj_q;
		prod_d      = prod_s1;
		mem_we      = 1'b0;
		mem_waddr   = cell_addr(ADW'(q_item.from_state), ADW'(q_item.action),
		                        ADW'(q_item.to_state));
		mem_wdata   = q_item.value;
		mem_raddr   = xf_addr;
		q_pop       = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_item.op == OP_SAMPLE && n_act != '0) begin
						iss_j_d = '0;
						sum_d   = '0;
						state_d = ST_SAMPLE;
					end else if (q_item.op == OP_XFORM && n_act != '0) begin
						xs_d    = '0;
						xa_d    = '0;
						xj_d    = '0;
						state_d = ST_XF_RD;
					end else if (res_free) begin
						// Writes, dropped commands and empty walks answer at once.
						mem_we      = (q_item.op == OP_WRITE);
						q_pop       = 1'b1;
						res_valid_d = 1'b1;
						res_next_d  = '0;
						res_found_d = 1'b0;
					end
				end
			end
			ST_SAMPLE: begin
				mem_raddr = cell_addr(ADW'(q_item.from_state), ADW'(q_item.action),
				                      ADW'(smp_j));
				if (iss_j_q < n_act) begin
					iss_j_d = iss_j_q + 1'b1;
					dv_d    = 1'b1;
					dj_d    = iss_j_q[SW-1:0];
				end
				if (dv_s1) begin
					sum_d = smp_sum;
					if (SUMW'(q_item.random_draw) < smp_sum) begin
						fin_next_d  = 4'(dj_s1);
						fin_found_d = 1'b1;
						dv_d        = 1'b0;
						state_d     = ST_DONE;
					end else if (NW'(dj_s1) + 1'b1 == n_act) begin
						fin_next_d  = '0;
						fin_found_d = 1'b0;
						dv_d        = 1'b0;
						state_d     = ST_DONE;
					end
				end
			end
			ST_XF_RD: begin
				state_d = ST_XF_MUL;
			end
			ST_XF_MUL: begin
				prod_d  = 34'(q_item.value) * 34'(rdata_q);
				state_d = ST_XF_WR;
			end
			ST_XF_WR: begin
				mem_we    = 1'b1;
				mem_waddr = xf_addr;
				mem_wdata = xf_val;
				state_d   = ST_XF_RD;
				if (!xf_j_wrap) begin
					xj_d = xj_q + 1'b1;
				end else begin
					xj_d = '0;
					if (!xf_a_wrap) begin
						xa_d = xa_q + 1'b1;
					end else begin
						xa_d = '0;
						if (!xf_s_wrap) begin
							xs_d = xs_q + 1'b1;
						end else begin
							fin_next_d  = '0;
							fin_found_d = 1'b0;
							state_d     = ST_DONE;
						end
					end
				end
			end
			ST_DONE: begin
				if (res_free) begin
					q_pop       = 1'b1;
					res_valid_d = 1'b1;
					res_next_d  = fin_next_q;
					res_found_d = fin_found_q;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			dv_s1       <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_valid_d;
			dv_s1       <= dv_d;
		end
	end

	always_ff @(posedge clk) begin
		res_next_q  <= res_next_d;
		res_found_q <= res_found_d;
		fin_next_q  <= fin_next_d;
		fin_found_q <= fin_found_d;
		iss_j_q     <= iss_j_d;
		dj_s1       <= dj_d;
		sum_q       <= sum_d;
		xs_q        <= xs_d;
		xa_q        <= xa_d;
		xj_q        <= xj_d;
		prod_s1     <= prod_d;
	end

	// Every retired command leaves exactly one result in the output register.
	a_pop_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> res_valid_q)
		else $error("retired command left no result");

	// The table is never written while a row is being walked.
	a_no_write_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SAMPLE) |-> !mem_we)
		else $error("table written during sampling walk");

	// A miss always reports state zero.
	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_found_q) |-> (res_next_q == '0))
		else $error("miss reported a nonzero state");

	// Nothing is retired unless a command waits at the queue head.
	a_pop_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("pop from empty queue");

endmodule

@@ sv/markov_next_state_sampler_top.sv @@
`timescale 1ns / 1ps

// Markov next-state sampler. Commands arrive as stream beats on s_* and each
// one returns exactly one result beat on m_*. A write stores one Q1.16
// probability. A sample walks the row (from_state, action) one table read
// per cycle through the table memory, which has one read and one write port.
// A transform rewrites every entry of the rows in use by read, multiply and
// write-back, one entry after another. A two-beat command queue sits in
// front of the execution unit and the result is held in an output register,
// so a new command is taken while a result waits. The table is not cleared
// at reset: read only entries that have been written. num_states is set
// through the APB port at address 0.

module markov_next_state_sampler_top import mnss_pkg::*; #(
	parameter int MAX_STATES  = DEF_MAX_STATES,
	parameter int MAX_ACTIONS = DEF_MAX_ACTIONS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// command[1:0], from_state[5:2], action[7:6], to_state[11:8],
	// value[28:12], random_draw[44:29], zero[47:45]
	input  logic [IN_W-1:0]    s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	// next_state[3:0], found[4], zero[7:5]
	output logic [OUT_W-1:0]   m_tdata,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [4:0] num_states_q;
	logic       q_full;
	logic       q_push;
	item_t      push_item;
	logic       q_valid;
	logic       q_pop;
	item_t      head_item;
	logic [3:0] next_state;
	logic       found;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_NUM_STATES) ? 32'(num_states_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q <= NUM_STATES_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_NUM_STATES) begin
			num_states_q <= pwdata[4:0];
		end
	end

	mnss_front #(
		.MAX_STATES (MAX_STATES),
		.MAX_ACTIONS(MAX_ACTIONS)
	) u_front (
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (push_item)
	);

	mnss_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_item(push_item),
		.full     (q_full),
		.pop      (q_pop),
		.valid    (q_valid),
		.head_item(head_item)
	);

	mnss_back #(
		.MAX_STATES (MAX_STATES),
		.MAX_ACTIONS(MAX_ACTIONS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.num_states    (num_states_q),
		.q_valid       (q_valid),
		.q_item        (head_item),
		.q_pop         (q_pop),
		.res_valid     (m_tvalid),
		.res_ready     (m_tready),
		.res_next_state(next_state),
		.res_found     (found)
	);

	assign m_tdata = {3'b000, found, next_state};

endmodule
